/* src/imuca_pkg.sv */
package imuca_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_ENTRIES = 24;
    // Steps beyond the angle table add nothing, so the sequencer stops there.
    localparam int STEPS_EFF = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
    localparam int STEP_W = (STEPS_EFF > 1) ? $clog2(STEPS_EFF) : 1;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_BLEND_WEIGHT   = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_GYRO_INCREMENT = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_TEMP_GAIN      = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_TEMP_OFFSET    = CFG_INDEX_W'(3);

    localparam logic [15:0] BLEND_WEIGHT_RST   = 16'd62415;
    localparam logic [15:0] GYRO_INCREMENT_RST = 16'd5120;
    localparam logic [15:0] TEMP_GAIN_RST      = 16'd50252;
    localparam logic [15:0] TEMP_OFFSET_RST    = 16'd5376;

    // +/-180 degrees in Q16.16.
    localparam logic signed [31:0] ANGLE_PI_POS = 32'sd11796480;
    localparam logic signed [31:0] ANGLE_PI_NEG = -32'sd11796480;

    // atan(2^-i) in Q16.16 degrees.
    localparam logic signed [31:0] ATAN_TAB [ATAN_ENTRIES] = '{
        32'sd2949120, 32'sd1740967, 32'sd919879, 32'sd466945,
        32'sd234379,  32'sd117304,  32'sd58666,  32'sd29335,
        32'sd14668,   32'sd7334,    32'sd3667,   32'sd1833,
        32'sd917,     32'sd458,     32'sd229,    32'sd115,
        32'sd57,      32'sd29,      32'sd14,     32'sd7,
        32'sd4,       32'sd2,       32'sd1,      32'sd0
    };

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] rate_x;
        logic signed [15:0] rate_y;
        logic signed [15:0] rate_z;
        logic signed [15:0] temp_sample;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] pitch_deg;
        logic signed [31:0] roll_deg;
        logic signed [31:0] yaw_deg;
        logic signed [15:0] temp_deg;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GX,
        S_GY,
        S_GZ,
        S_TEMP,
        S_CINIT,
        S_CITER,
        S_BP,
        S_BR,
        S_DONE
    } t_state;

endpackage

/* src/imu_complementary_attitude.sv */
// Complementary attitude filter for a six-axis inertial sensor.
//
// The input channel (i_valid / o_stall) carries one raw sample: three
// acceleration axes, three angular rates and a temperature reading. The
// output channel (o_valid / i_stall) returns one result per sample: pitch,
// roll and yaw in Q16.16 degrees and temperature in Q8.8 Celsius.
//
// After its transfer a sample steps through GX, GY, GZ, TEMP, then CINIT and
// CITER for each angle, then BP, BR and DONE, which loads the result and
// raises o_valid. A new sample is taken only in idle, once the last is through.
// The block has one shared 17 x 34 bit multiplier (six products) and one
// shift-add CORDIC stage that runs CORDIC_STEPS iterations per angle, two
// angles per sample. o_stall stays high while a sample is being processed.
//
// If the receiver stalls, the result waits in the output register; a new
// sample is still taken, and its result waits until the previous one has
// been transferred. Configuration writes are taken any cycle but should be
// issued only while the block is idle. Reset clears the angle accumulators
// and o_valid and loads the default configuration values.
module imu_complementary_attitude (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  imuca_pkg::t_in_item               i_item,
    output logic                              o_valid,
    input  logic                              i_stall,
    output imuca_pkg::t_out_item              o_item,
    input  logic                              i_cfg_we,
    input  logic [imuca_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [imuca_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import imuca_pkg::*;

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(STEPS_EFF - 1);

    t_state r_state, n_state;

    logic [15:0]        r_blend_weight;
    logic [15:0]        r_gyro_increment;
    logic [15:0]        r_temp_gain;
    logic signed [15:0] r_temp_offset;

    logic signed [31:0] r_pitch_acc;
    logic signed [31:0] r_roll_acc;
    logic signed [31:0] r_yaw_acc;

    t_in_item           r_in;
    logic signed [50:0] r_prod;
    logic signed [33:0] r_pitch_g;
    logic signed [33:0] r_roll_g;
    logic signed [31:0] r_pitch_a;
    logic signed [31:0] r_roll_a;
    logic signed [15:0] r_temp;

    logic signed [33:0] r_x;
    logic signed [33:0] r_y;
    logic signed [31:0] r_z;
    logic [STEP_W-1:0]  r_step;
    logic               r_csel;
    logic               r_czero;

    logic               r_valid;
    t_out_item          r_out;

    // Control from the output decoder.
    logic               mul_en;
    logic signed [16:0] mul_a;
    logic signed [33:0] mul_b;
    logic               load_out;

    // Datapath terms.
    logic signed [50:0] gyro_sum;
    logic signed [24:0] gyro_d;
    logic signed [50:0] temp_sum;
    logic signed [16:0] temp_scaled;
    logic signed [17:0] temp_total;
    logic signed [15:0] temp_sat;
    logic signed [50:0] blend_sum;
    logic signed [34:0] blend_q;
    logic signed [35:0] blend_pitch;
    logic signed [35:0] blend_roll;
    logic signed [31:0] pitch_new;
    logic signed [31:0] roll_new;

    logic signed [15:0] c_num;
    logic signed [15:0] c_den;
    logic signed [33:0] c_num_s;
    logic signed [33:0] c_den_s;
    logic signed [33:0] x_sh;
    logic signed [33:0] y_sh;
    logic signed [31:0] atan_val;
    logic signed [33:0] x_next;
    logic signed [33:0] y_next;
    logic signed [31:0] z_next;
    logic signed [31:0] angle_fin;

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        if (v > 36'sh0_7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -36'sh0_8000_0000) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_valid) n_state = S_GX;
            S_GX:    n_state = S_GY;
            S_GY:    n_state = S_GZ;
            S_GZ:    n_state = S_TEMP;
            S_TEMP:  n_state = S_CINIT;
            S_CINIT: n_state = S_CITER;
            S_CITER: begin
                if (r_step == STEP_LAST) begin
                    n_state = r_csel ? S_BP : S_CINIT;
                end
            end
            S_BP:    n_state = S_BR;
            S_BR:    n_state = S_DONE;
            S_DONE:  if (!r_valid || !i_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs: multiplier operands and handshake controls.
    always_comb begin
        mul_en   = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
        load_out = 1'b0;
        o_stall  = (r_state != S_IDLE);
        unique case (r_state)
            S_GX: begin
                mul_en = 1'b1;
                mul_a  = {1'b0, r_gyro_increment};
                mul_b  = 34'(r_in.rate_x);
            end
            S_GY: begin
                mul_en = 1'b1;
                mul_a  = {1'b0, r_gyro_increment};
                mul_b  = 34'(r_in.rate_y);
            end
            S_GZ: begin
                mul_en = 1'b1;
                mul_a  = {1'b0, r_gyro_increment};
                mul_b  = 34'(r_in.rate_z);
            end
            S_TEMP: begin
                mul_en = 1'b1;
                mul_a  = {1'b0, r_temp_gain};
                mul_b  = 34'(r_in.temp_sample);
            end
            // w*g + (1-w)*a equals a*2^16 + w*(g-a), so one product per axis.
            S_BP: begin
                mul_en = 1'b1;
                mul_a  = {1'b0, r_blend_weight};
                mul_b  = r_pitch_g - 34'(r_pitch_a);
            end
            S_BR: begin
                mul_en = 1'b1;
                mul_a  = {1'b0, r_blend_weight};
                mul_b  = r_roll_g - 34'(r_roll_a);
            end
            S_DONE:  load_out = !r_valid || !i_stall;
            default: ;
        endcase
    end

    // Rounded products. Each product fits the bits that are selected.
    always_comb begin
        gyro_sum    = r_prod + 51'sd128;
        gyro_d      = gyro_sum[32:8];
        temp_sum    = r_prod + 51'sd32768;
        temp_scaled = temp_sum[32:16];
        temp_total  = 18'(temp_scaled) + 18'(r_temp_offset);
        if (temp_total > 18'sd32767) begin
            temp_sat = 16'sh7FFF;
        end else if (temp_total < -18'sd32768) begin
            temp_sat = 16'sh8000;
        end else begin
            temp_sat = temp_total[15:0];
        end
        blend_sum   = r_prod + 51'sd32768;
        blend_q     = blend_sum[50:16];
        blend_pitch = 36'(blend_q) + 36'(r_pitch_a);
        blend_roll  = 36'(blend_q) + 36'(r_roll_a);
        pitch_new   = sat32(blend_pitch);
        roll_new    = sat32(blend_roll);
    end

    // CORDIC vectoring stage.
    always_comb begin
        c_num    = r_csel ? r_in.accel_x : r_in.accel_y;
        c_den    = r_in.accel_z;
        c_num_s  = {{4{c_num[15]}}, c_num, 14'b0};
        c_den_s  = {{4{c_den[15]}}, c_den, 14'b0};
        x_sh     = r_x >>> r_step;
        y_sh     = r_y >>> r_step;
        atan_val = ATAN_TAB[5'(r_step)];
        if (!r_y[33]) begin
            x_next = r_x + y_sh;
            y_next = r_y - x_sh;
            z_next = r_z + atan_val;
        end else begin
            x_next = r_x - y_sh;
            y_next = r_y + x_sh;
            z_next = r_z - atan_val;
        end
        angle_fin = r_czero ? 32'sd0 : z_next;
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_valid          <= 1'b0;
            r_csel           <= 1'b0;
            r_blend_weight   <= BLEND_WEIGHT_RST;
            r_gyro_increment <= GYRO_INCREMENT_RST;
            r_temp_gain      <= TEMP_GAIN_RST;
            r_temp_offset    <= TEMP_OFFSET_RST;
            r_pitch_acc      <= '0;
            r_roll_acc       <= '0;
            r_yaw_acc        <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_BLEND_WEIGHT:   r_blend_weight   <= i_cfg_data;
                    REG_GYRO_INCREMENT: r_gyro_increment <= i_cfg_data;
                    REG_TEMP_GAIN:      r_temp_gain      <= i_cfg_data;
                    REG_TEMP_OFFSET:    r_temp_offset    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == S_IDLE) begin
                r_csel <= 1'b0;
            end else if (r_state == S_CITER && r_step == STEP_LAST) begin
                r_csel <= 1'b1;
            end
            if (r_state == S_TEMP) begin
                r_yaw_acc <= r_yaw_acc + 32'(gyro_d);
            end
            if (r_state == S_BR) begin
                r_pitch_acc <= pitch_new;
            end
            if (load_out) begin
                r_roll_acc <= roll_new;
                r_valid    <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_in <= i_item;
        end
        if (mul_en) begin
            r_prod <= 51'(mul_a) * 51'(mul_b);
        end
        unique case (r_state)
            S_GY:   r_pitch_g <= 34'(r_pitch_acc) + 34'(gyro_d);
            S_GZ:   r_roll_g  <= 34'(r_roll_acc) - 34'(gyro_d);
            S_CINIT: begin
                r_step  <= '0;
                r_czero <= (c_num == 16'sd0) && (c_den == 16'sd0);
                if (c_den[15]) begin
                    r_x <= -c_den_s;
                    r_y <= -c_num_s;
                    r_z <= c_num[15] ? ANGLE_PI_NEG : ANGLE_PI_POS;
                end else begin
                    r_x <= c_den_s;
                    r_y <= c_num_s;
                    r_z <= '0;
                end
                if (!r_csel) begin
                    r_temp <= temp_sat;
                end
            end
            S_CITER: begin
                r_x    <= x_next;
                r_y    <= y_next;
                r_z    <= z_next;
                r_step <= r_step + 1'b1;
                if (r_step == STEP_LAST) begin
                    if (r_csel) begin
                        r_roll_a <= angle_fin;
                    end else begin
                        r_pitch_a <= angle_fin;
                    end
                end
            end
            default: ;
        endcase
        if (load_out) begin
            r_out.pitch_deg <= r_pitch_acc;
            r_out.roll_deg  <= roll_new;
            r_out.yaw_deg   <= r_yaw_acc;
            r_out.temp_deg  <= r_temp;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_out;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == S_GX))
        else $error("transfer did not start the sequencer");

    a_step_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CITER && r_step != STEP_LAST)
            |=> (r_state == S_CITER && r_step == $past(r_step) + 1'b1))
        else $error("CORDIC iteration count skipped");

    a_second_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CITER && r_step == STEP_LAST && r_csel) |=> (r_state == S_BP))
        else $error("blend did not follow the second angle");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == S_DONE))
        else $error("result appeared outside the final step");

endmodule

/* bench/imuca_checker.sv */
module imuca_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_stall,
    input  imuca_pkg::t_in_item               i_in_item,
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  imuca_pkg::t_out_item              i_out_item,
    input  logic                              i_cfg_we,
    input  logic [imuca_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [imuca_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                                o_fail_count,
    output int                                o_pending
);
    import imuca_pkg::*;

    localparam int ARC_ENTRIES = 24;
    localparam int ARC_STEPS = (CORDIC_STEPS > ARC_ENTRIES) ? ARC_ENTRIES : CORDIC_STEPS;
    localparam longint HALF_TURN = 180 * 65536;
    localparam longint Q_MAX = 64'sd2147483647;
    localparam longint Q_MIN = -64'sd2147483648;

    // atan(2^-i) in Q16.16 degrees.
    localparam longint ARCTAN_Q16 [ARC_ENTRIES] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    logic signed [31:0] pitch_q;
    logic signed [31:0] roll_q;
    logic signed [31:0] yaw_q;
    logic [15:0]        weight;
    logic [15:0]        gyro_inc;
    logic [15:0]        t_gain;
    logic signed [15:0] t_offset;

    t_out_item attitude_q [$];
    int        fails = 0;

    function automatic longint accel_angle(longint n, longint d);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        if (n == 0 && d == 0) begin
            return 0;
        end
        x = d * 16384;
        y = n * 16384;
        z = 0;
        // A vector in the left half plane is folded over and starts at +/-180.
        if (d < 0) begin
            z = (n >= 0) ? HALF_TURN : -HALF_TURN;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < ARC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + ARCTAN_Q16[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - ARCTAN_Q16[i];
            end
        end
        return z;
    endfunction

    function automatic longint rate_delta(logic signed [15:0] rate);
        return (longint'(rate) * longint'(gyro_inc) + 128) >>> 8;
    endfunction

    function automatic logic signed [31:0] fuse(longint g, longint a);
        longint w;
        longint v;
        w = longint'(weight);
        v = (w * g + (65536 - w) * a + 32768) >>> 16;
        if (v > Q_MAX) begin
            v = Q_MAX;
        end else if (v < Q_MIN) begin
            v = Q_MIN;
        end
        return v[31:0];
    endfunction

    // Advances the attitude state by one sample and returns the result it yields.
    function automatic t_out_item advance_attitude(t_in_item s);
        t_out_item r;
        longint    pitch_g;
        longint    roll_g;
        longint    dz;
        longint    t;
        pitch_g = longint'(pitch_q) + rate_delta(s.rate_x);
        roll_g = longint'(roll_q) - rate_delta(s.rate_y);
        dz = rate_delta(s.rate_z);
        yaw_q = yaw_q + dz[31:0];
        pitch_q = fuse(pitch_g, accel_angle(longint'(s.accel_y), longint'(s.accel_z)));
        roll_q = fuse(roll_g, accel_angle(longint'(s.accel_x), longint'(s.accel_z)));
        t = ((longint'(s.temp_sample) * longint'(t_gain) + 32768) >>> 16)
            + longint'(t_offset);
        if (t > 32767) begin
            t = 32767;
        end else if (t < -32768) begin
            t = -32768;
        end
        r.pitch_deg = pitch_q;
        r.roll_deg = roll_q;
        r.yaw_deg = yaw_q;
        r.temp_deg = t[15:0];
        return r;
    endfunction

    function automatic int field_differs(string name, longint want, longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (!i_rst_n) begin
            pitch_q = '0;
            roll_q = '0;
            yaw_q = '0;
            weight = BLEND_WEIGHT_RST;
            gyro_inc = GYRO_INCREMENT_RST;
            t_gain = TEMP_GAIN_RST;
            t_offset = TEMP_OFFSET_RST;
            attitude_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_BLEND_WEIGHT:   weight = i_cfg_data;
                    REG_GYRO_INCREMENT: gyro_inc = i_cfg_data;
                    REG_TEMP_GAIN:      t_gain = i_cfg_data;
                    REG_TEMP_OFFSET:    t_offset = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                attitude_q.push_back(advance_attitude(i_in_item));
            end
            if (i_out_valid && !i_out_stall) begin
                if (attitude_q.size() == 0) begin
                    $display("%0t: result transfer with no sample outstanding", $time);
                    fails++;
                end else begin
                    want = attitude_q.pop_front();
                    fails += field_differs("pitch_deg", want.pitch_deg, i_out_item.pitch_deg);
                    fails += field_differs("roll_deg", want.roll_deg, i_out_item.roll_deg);
                    fails += field_differs("yaw_deg", want.yaw_deg, i_out_item.yaw_deg);
                    fails += field_differs("temp_deg", want.temp_deg, i_out_item.temp_deg);
                end
            end
        end
        o_pending = attitude_q.size();
        o_fail_count = fails;
    end

endmodule

/* bench/tb_imu_complementary_attitude.sv */
module tb_imu_complementary_attitude;
    import imuca_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_AT = 60;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 60;
    localparam logic signed [15:0] MAX16 = 16'sh7FFF;
    localparam logic signed [15:0] MIN16 = 16'sh8000;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    t_in_item               in_item = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b1;
    t_out_item              out_item;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    int                     fail_count;
    int                     pending;
    bit                     idle_on = 1'b1;

    imu_complementary_attitude u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (in_valid),
        .o_stall     (in_stall),
        .i_item      (in_item),
        .o_valid     (out_valid),
        .i_stall     (out_stall),
        .o_item      (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    imuca_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic logic signed [15:0] raw_value();
        case ($urandom_range(0, 9))
            0: return MIN16;
            1: return MAX16;
            2: return '0;
            3: return 16'($urandom_range(0, 16) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_in_item random_sample();
        t_in_item s;
        s.accel_x = raw_value();
        s.accel_y = raw_value();
        s.accel_z = raw_value();
        s.rate_x = raw_value();
        s.rate_y = raw_value();
        s.rate_z = raw_value();
        s.temp_sample = raw_value();
        return s;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_sample(input t_in_item s);
        int gap;
        gap = idle_on ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item <= s;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic program_setting(input logic [15:0] w, input logic [15:0] inc,
                                   input logic [15:0] gain, input logic signed [15:0] off);
        cfg_we <= 1'b1;
        cfg_index <= REG_BLEND_WEIGHT;
        cfg_data <= w;
        @(negedge clk);
        cfg_index <= REG_GYRO_INCREMENT;
        cfg_data <= inc;
        @(negedge clk);
        cfg_index <= REG_TEMP_GAIN;
        cfg_data <= gain;
        @(negedge clk);
        cfg_index <= REG_TEMP_OFFSET;
        cfg_data <= off;
        @(negedge clk);
        // An index past the last register must leave every setting alone.
        cfg_index <= CFG_INDEX_W'($urandom_range(int'(REG_TEMP_OFFSET) + 1,
                                                 (1 << CFG_INDEX_W) - 1));
        cfg_data <= 16'($urandom);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Drains the block, applies a new setting and streams samples under it.
    task automatic run_phase(input logic [15:0] w, input logic [15:0] inc,
                             input logic [15:0] gain, input logic signed [15:0] off,
                             input int count, input bit idle, input bit spin);
        t_in_item s;
        wait (pending == 0);
        @(negedge clk);
        program_setting(w, inc, gain, off);
        idle_on = idle;
        for (int k = 0; k < count; k++) begin
            s = random_sample();
            // Sustained full-scale rates drive pitch and roll into saturation
            // and make yaw wrap.
            if (spin) begin
                s.rate_x = MAX16 - 16'($urandom_range(0, 63));
                s.rate_y = MAX16 - 16'($urandom_range(0, 63));
                s.rate_z = MAX16 - 16'($urandom_range(0, 63));
            end
            send_sample(s);
        end
        in_valid <= 1'b0;
    endtask

    initial begin : stimulus
        t_in_item corner [$];
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        corner.push_back(t_in_item'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
        corner.push_back(t_in_item'{MAX16, MAX16, MAX16, MAX16, MAX16, MAX16, MAX16});
        corner.push_back(t_in_item'{MIN16, MIN16, MIN16, MIN16, MIN16, MIN16, MIN16});
        corner.push_back(t_in_item'{16'sd0, 16'sd0, 16'sd0, 16'sd1, -16'sd1, 16'sd1, 16'sd0});
        corner.push_back(t_in_item'{16'sd0, 16'sd100, -16'sd200, 16'sd0, 16'sd0, 16'sd0,
                                    16'sd100});
        corner.push_back(t_in_item'{16'sd0, -16'sd100, -16'sd200, 16'sd0, 16'sd0, 16'sd0,
                                    -16'sd100});
        corner.push_back(t_in_item'{16'sd0, 16'sd0, -16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
        corner.push_back(t_in_item'{16'sd5, 16'sd5, 16'sd0, 16'sd3, 16'sd3, 16'sd3, 16'sd1});
        corner.push_back(t_in_item'{-16'sd5, -16'sd5, 16'sd0, -16'sd3, -16'sd3, -16'sd3,
                                    -16'sd1});
        corner.push_back(t_in_item'{MIN16, MAX16, MIN16, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
        corner.push_back(t_in_item'{MAX16, MIN16, 16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
        corner.push_back(t_in_item'{16'sd1, 16'sd1, 16'sd1, MIN16, MAX16, MIN16, MAX16});
        corner.push_back(t_in_item'{-16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1,
                                    -16'sd1});
        corner.push_back(t_in_item'{16'sd0, 16'sd0, MAX16, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
        corner.push_back(t_in_item'{16'sd0, 16'sd0, MIN16, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
        corner.push_back(t_in_item'{16'sd12345, -16'sd23456, 16'sd3000, 16'sd777, -16'sd888,
                                    16'sd999, 16'sd2500});

        // Reset values of the configuration are in force for the first phase.
        foreach (corner[i]) begin
            send_sample(corner[i]);
        end
        for (int k = 0; k < 150; k++) begin
            send_sample(random_sample());
        end
        in_valid <= 1'b0;

        run_phase(16'd0, 16'hFFFF, 16'hFFFF, MAX16, 120, 1'b0, 1'b0);
        run_phase(16'hFFFF, 16'd0, 16'd0, MIN16, 120, 1'b1, 1'b0);
        run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, MIN16, 300, 1'b1, 1'b1);
        run_phase(16'd32768, 16'd1, 16'd1, 16'sd0, 120, 1'b1, 1'b0);
        run_phase(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 110, 1'b1, 1'b0);
        run_phase(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 110, 1'b0, 1'b0);
        run_phase(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 110, 1'b1, 1'b0);

        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin : drain_results
        int gap;
        int taken;
        taken = 0;
        wait (rst_n);
        @(negedge clk);
        forever begin
            gap = idle_on ? $urandom_range(0, 9) : 0;
            // One long hold-off lets the block fill up and push back on the sender.
            if (taken == HOLD_AT) begin
                gap = HOLD_CYCLES;
            end
            if (gap == 0) begin
                out_stall <= 1'b0;
            end else begin
                out_stall <= 1'b1;
                do @(posedge clk); while (!out_valid);
                repeat (gap) @(negedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!out_valid);
            taken++;
            @(negedge clk);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("TB_ERROR");
        $finish;
    end

endmodule

/* files.f */
src/imuca_pkg.sv
src/imu_complementary_attitude.sv
bench/imuca_checker.sv
bench/tb_imu_complementary_attitude.sv
